[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[hw/rtl/dps_pkg.sv]
// ----------------------------------------------------------------------------
// dps_pkg
// Widths, stage counts and lane payload type for the distance shading block.
// ----------------------------------------------------------------------------
package dps_pkg;

   localparam int CHAN_BITS     = 8;
   localparam int NUM_CHANS     = 4;
   localparam int PIX_BITS      = CHAN_BITS * NUM_CHANS;
   localparam int VIEW_BITS     = 16;
   localparam int REQ_DIST_BITS = 16;
   localparam int DIST_BITS     = 16;

   // Only the low DIST_BITS of the distance take part.
   localparam int DIST_USED = (DIST_BITS < REQ_DIST_BITS) ? DIST_BITS : REQ_DIST_BITS;
   localparam logic [REQ_DIST_BITS-1:0] DIST_MASK =
      REQ_DIST_BITS'((33'd1 << DIST_USED) - 33'd1);

   localparam logic [VIEW_BITS-1:0] VIEW_RESET = VIEW_BITS'(256);
   localparam logic [VIEW_BITS-1:0] VIEW_MIN   = VIEW_BITS'(2);

   // range = view-1 fits VIEW_BITS; range + 3*(d-1) needs two more bits.
   localparam int DEN_BITS   = ((VIEW_BITS > REQ_DIST_BITS) ? VIEW_BITS : REQ_DIST_BITS) + 2;
   localparam int NUM_BITS   = CHAN_BITS + VIEW_BITS;
   localparam int TRIAL_BITS = ((NUM_BITS > DEN_BITS + CHAN_BITS) ?
                                NUM_BITS : DEN_BITS + CHAN_BITS) + 1;

   // One quotient bit per divider stage; quotient never exceeds the channel.
   localparam int DIV_STAGES   = CHAN_BITS;
   localparam int FRONT_STAGES = 2;
   localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

   typedef struct packed {
      logic [NUM_BITS-1:0] num;
      logic [DEN_BITS-1:0] den;
   } div_type;

endpackage

[hw/rtl/dps_front.sv]
// ----------------------------------------------------------------------------
// dps_front
// Clamps distance and view, forms the shared divisor and per-lane numerators.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dps_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take,
   input  logic [dps_pkg::PIX_BITS-1:0]      pixel,
   input  logic [dps_pkg::REQ_DIST_BITS-1:0] ray_dist,
   input  logic [dps_pkg::VIEW_BITS-1:0]     view,
   output logic                              div_vld,
   output dps_pkg::div_type                  div_out [dps_pkg::NUM_CHANS]
);

   logic                              vld_a_ff;
   logic                              vld_b_ff;
   logic [dps_pkg::PIX_BITS-1:0]      pix_a_ff;
   logic [dps_pkg::VIEW_BITS-1:0]     range_a_ff;
   logic [dps_pkg::VIEW_BITS-1:0]     range_a_in;
   logic [dps_pkg::REQ_DIST_BITS-1:0] dm1_a_ff;
   logic [dps_pkg::REQ_DIST_BITS-1:0] dm1_a_in;
   logic [dps_pkg::REQ_DIST_BITS-1:0] dist_m;
   logic [dps_pkg::DEN_BITS-1:0]      den_in;
   dps_pkg::div_type                  div_ff [dps_pkg::NUM_CHANS];
   dps_pkg::div_type                  div_in [dps_pkg::NUM_CHANS];

   // Stage A: clamp zero distance to one and view below two to two.
   always_comb begin
      dist_m     = ray_dist & dps_pkg::DIST_MASK;
      dm1_a_in   = (dist_m == '0) ? '0 : dist_m - dps_pkg::REQ_DIST_BITS'(1);
      range_a_in = (view < dps_pkg::VIEW_MIN) ? dps_pkg::VIEW_BITS'(1)
                                              : view - dps_pkg::VIEW_BITS'(1);
   end

   // Stage B: divisor range + 3*(d-1), numerators chan*range.
   always_comb begin
      den_in = dps_pkg::DEN_BITS'(range_a_ff) + dps_pkg::DEN_BITS'(dm1_a_ff)
             + (dps_pkg::DEN_BITS'(dm1_a_ff) << 1);
      for (int i = 0; i < dps_pkg::NUM_CHANS; i++) begin
         div_in[i].num = dps_pkg::NUM_BITS'(pix_a_ff[i*dps_pkg::CHAN_BITS +: dps_pkg::CHAN_BITS])
                       * dps_pkg::NUM_BITS'(range_a_ff);
         div_in[i].den = den_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= take;
         vld_b_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      pix_a_ff   <= pixel;
      range_a_ff <= range_a_in;
      dm1_a_ff   <= dm1_a_in;
      div_ff     <= div_in;
   end

   assign div_vld = vld_b_ff;
   assign div_out = div_ff;

   // Quotient must fit a channel: num < den << CHAN_BITS on every lane.
   for (genvar g = 0; g < dps_pkg::NUM_CHANS; g++) begin : g_chk
      logic quo_fits;
      assign quo_fits = dps_pkg::TRIAL_BITS'(div_ff[g].num)
                      < (dps_pkg::TRIAL_BITS'(div_ff[g].den) << dps_pkg::CHAN_BITS);
      `ASSERT_CLK(a_quo_fits, clock, reset, vld_b_ff |-> quo_fits)
   end
   `ASSERT_NEVER(a_den_nonzero, clock, reset, vld_b_ff && div_ff[0].den == '0)

endmodule

[hw/rtl/dps_lane.sv]
// ----------------------------------------------------------------------------
// dps_lane
// Pipelined restoring divider for one channel, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dps_lane (
   input  logic                          clock,
   input  dps_pkg::div_type              div_in,
   output logic [dps_pkg::CHAN_BITS-1:0] quo
);

   localparam int LAST = dps_pkg::DIV_STAGES - 1;

   logic [dps_pkg::NUM_BITS-1:0]  rem_ff [LAST];
   logic [dps_pkg::DEN_BITS-1:0]  den_ff [LAST];
   logic [dps_pkg::CHAN_BITS-1:0] quo_ff [dps_pkg::DIV_STAGES];

   for (genvar k = 0; k < dps_pkg::DIV_STAGES; k++) begin : g_stage
      localparam int SH = dps_pkg::CHAN_BITS - 1 - k;

      logic [dps_pkg::NUM_BITS-1:0]   rem_cur;
      logic [dps_pkg::DEN_BITS-1:0]   den_cur;
      logic [dps_pkg::CHAN_BITS-1:0]  quo_cur;
      logic [dps_pkg::TRIAL_BITS-1:0] trial;
      logic                           fits;
      logic [dps_pkg::CHAN_BITS-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign rem_cur = div_in.num;
         assign den_cur = div_in.den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      // Try subtracting den scaled to this quotient bit; keep if it fits.
      assign trial  = dps_pkg::TRIAL_BITS'(den_cur) << SH;
      assign fits   = dps_pkg::TRIAL_BITS'(rem_cur) >= trial;
      assign quo_in = fits ? (quo_cur | (dps_pkg::CHAN_BITS'(1) << SH)) : quo_cur;

      always_ff @(posedge clock) begin
         quo_ff[k] <= quo_in;
      end

      if (k < LAST) begin : g_carry
         logic [dps_pkg::NUM_BITS-1:0] rem_in;

         assign rem_in = fits ? dps_pkg::NUM_BITS'(dps_pkg::TRIAL_BITS'(rem_cur) - trial)
                              : rem_cur;

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_cur;
         end
      end
   end

   assign quo = quo_ff[LAST];

endmodule

[hw/rtl/distance_pixel_shading.sv]
// ----------------------------------------------------------------------------
// distance_pixel_shading
// Linear distance fog: each RGBA channel scaled by range / (range + 3*(d-1)).
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  request   req_pixel_in, req_ray_distance               start & !busy
//  result    rsp_shaded_pixel                             rsp_valid, one cycle
//  csr       csr_wr_data (view range)                     csr_wr_en
//
//  One request per cycle while busy is low; each accepted request passes
//  through the clamp register, multiply register, 8 divider stages (one quotient
//  bit each, four channel lanes side by side) and the merge register.
//  busy is high during reset and in the cycle after it; synchronous reset
//  clears the valid pipeline and loads the view range with 256.
//  Results are never held: the receiver takes each one in its strobe cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module distance_pixel_shading (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [dps_pkg::PIX_BITS-1:0]      req_pixel_in,
   input  logic [dps_pkg::REQ_DIST_BITS-1:0] req_ray_distance,
   output logic                              rsp_valid,
   output logic [dps_pkg::PIX_BITS-1:0]      rsp_shaded_pixel,
   input  logic                              csr_wr_en,
   input  logic [dps_pkg::VIEW_BITS-1:0]     csr_wr_data
);

   logic                          busy_ff;
   logic                          take;
   logic [dps_pkg::VIEW_BITS-1:0] view_ff;
   logic                          div_vld;
   dps_pkg::div_type              div_bus [dps_pkg::NUM_CHANS];
   logic [dps_pkg::CHAN_BITS-1:0] quo [dps_pkg::NUM_CHANS];
   logic [dps_pkg::DIV_STAGES-1:0] vld_ff;
   logic [dps_pkg::DIV_STAGES-1:0] vld_in;
   logic                          rsp_vld_ff;
   logic [dps_pkg::PIX_BITS-1:0]  pix_ff;
   logic [dps_pkg::PIX_BITS-1:0]  pix_in;
   logic                          zero_dist;

   assign take = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         view_ff <= dps_pkg::VIEW_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) begin
            view_ff <= csr_wr_data;
         end
      end
   end

   dps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .pixel    (req_pixel_in),
      .ray_dist (req_ray_distance),
      .view     (view_ff),
      .div_vld  (div_vld),
      .div_out  (div_bus)
   );

   for (genvar i = 0; i < dps_pkg::NUM_CHANS; i++) begin : g_lane
      dps_lane u_lane (
         .clock  (clock),
         .div_in (div_bus[i]),
         .quo    (quo[i])
      );
   end

   // Track request valid alongside the divider stages.
   assign vld_in = {vld_ff[dps_pkg::DIV_STAGES-2:0], div_vld};

   // Merge: repack lane quotients in the original channel order.
   always_comb begin
      for (int i = 0; i < dps_pkg::NUM_CHANS; i++) begin
         pix_in[i*dps_pkg::CHAN_BITS +: dps_pkg::CHAN_BITS] = quo[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         rsp_vld_ff <= vld_ff[dps_pkg::DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_vld_ff;
   assign rsp_shaded_pixel = pix_ff;

   assign zero_dist = (req_ray_distance & dps_pkg::DIST_MASK) == '0;

   `ASSERT_CLK(a_rsp_has_req, clock, reset, rsp_valid |-> $past(take, dps_pkg::LATENCY))
   `ASSERT_CLK(a_req_gets_rsp, clock, reset, take |-> ##(dps_pkg::LATENCY) rsp_valid)
   `ASSERT_CLK(a_zero_dist_passes, clock, reset, (take && zero_dist) |-> ##(dps_pkg::LATENCY) (rsp_shaded_pixel == $past(req_pixel_in, dps_pkg::LATENCY)))

endmodule

[sim/dps_shading_checker.sv]
// ----------------------------------------------------------------------------
// dps_shading_checker
// Watches the request, result and csr ports of the distance shading block,
// keeps its own copy of the view range, predicts each shaded pixel and
// compares every strobed result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module dps_shading_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [dps_pkg::PIX_BITS-1:0]      req_pixel_in,
   input  logic [dps_pkg::REQ_DIST_BITS-1:0] req_ray_distance,
   input  logic                              rsp_valid,
   input  logic [dps_pkg::PIX_BITS-1:0]      rsp_shaded_pixel,
   input  logic                              csr_wr_en,
   input  logic [dps_pkg::VIEW_BITS-1:0]     csr_wr_data,
   output int                                failures,
   output int                                pending,
   output int                                compared
);

   logic [dps_pkg::PIX_BITS-1:0]  shaded_expected [$];
   logic [dps_pkg::PIX_BITS-1:0]  shaded_want;
   logic [dps_pkg::VIEW_BITS-1:0] view_setting;

   // Each channel becomes floor(c * span / (span + 3*(d-1))), span = view - 1.
   function automatic logic [dps_pkg::PIX_BITS-1:0] fog_shade(
      input logic [dps_pkg::PIX_BITS-1:0]      pix,
      input logic [dps_pkg::REQ_DIST_BITS-1:0] ray_dist,
      input logic [dps_pkg::VIEW_BITS-1:0]     view
   );
      logic [63:0]                  d;
      logic [63:0]                  v;
      logic [63:0]                  span;
      logic [63:0]                  den;
      logic [63:0]                  chan;
      logic [dps_pkg::PIX_BITS-1:0] shaded;
      d = 64'(ray_dist & dps_pkg::DIST_MASK);
      v = 64'(view);
      if (d == 64'd0)
         d = 64'd1;
      if (v < 64'(dps_pkg::VIEW_MIN))
         v = 64'(dps_pkg::VIEW_MIN);
      span = v - 64'd1;
      den  = span + 64'd3 * (d - 64'd1);
      shaded = '0;
      for (int k = 0; k < dps_pkg::NUM_CHANS; k++) begin
         chan = 64'(pix[k*dps_pkg::CHAN_BITS +: dps_pkg::CHAN_BITS]);
         shaded[k*dps_pkg::CHAN_BITS +: dps_pkg::CHAN_BITS] =
            dps_pkg::CHAN_BITS'((chan * span) / den);
      end
      return shaded;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] shading check: %s", $time, msg);
      failures++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shaded_expected.delete();
         view_setting = dps_pkg::VIEW_RESET;
      end else begin
         if (rsp_valid) begin
            if (shaded_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected result %08h, nothing pending",
                                         rsp_shaded_pixel));
            end else begin
               shaded_want = shaded_expected.pop_front();
               compared++;
               if (rsp_shaded_pixel !== shaded_want)
                  report_mismatch($sformatf("shaded_pixel expected %08h got %08h",
                                            shaded_want, rsp_shaded_pixel));
            end
         end
         // predict with the setting in force before any write at this edge
         if (start && !busy)
            shaded_expected.insert(shaded_expected.size(),
                                   fog_shade(req_pixel_in, req_ray_distance,
                                             view_setting));
         if (csr_wr_en)
            view_setting = csr_wr_data;
      end
      pending = shaded_expected.size();
   end

endmodule

[sim/tb_distance_pixel_shading.sv]
// ----------------------------------------------------------------------------
// tb_distance_pixel_shading
// Drives pixels and ray distances into the shading block under a series of
// view distance settings, with random and burst gaps between requests; the
// checker beside the block predicts and compares every shaded pixel.
// ----------------------------------------------------------------------------
module tb_distance_pixel_shading;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [dps_pkg::PIX_BITS-1:0]      req_pixel_in;
   logic [dps_pkg::REQ_DIST_BITS-1:0] req_ray_distance;
   logic                              rsp_valid;
   logic [dps_pkg::PIX_BITS-1:0]      rsp_shaded_pixel;
   logic                              csr_wr_en;
   logic [dps_pkg::VIEW_BITS-1:0]     csr_wr_data;

   int failures;
   int pending;
   int compared;
   int burst_left;
   int requests_sent;
   int settings_used;

   logic [dps_pkg::VIEW_BITS-1:0] view_now;
   logic [dps_pkg::VIEW_BITS-1:0] view_plan [10];

   distance_pixel_shading dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pixel_in     (req_pixel_in),
      .req_ray_distance (req_ray_distance),
      .rsp_valid        (rsp_valid),
      .rsp_shaded_pixel (rsp_shaded_pixel),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   dps_shading_checker shading_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_pixel_in     (req_pixel_in),
      .req_ray_distance (req_ray_distance),
      .rsp_valid        (rsp_valid),
      .rsp_shaded_pixel (rsp_shaded_pixel),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .failures         (failures),
      .pending          (pending),
      .compared         (compared)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_request(input logic [dps_pkg::PIX_BITS-1:0] pix,
                               input logic [dps_pkg::REQ_DIST_BITS-1:0] ray_dist);
      int gap;
      bit taken;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 5);
         if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(8, 40);
      end
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            <= 1'b1;
      req_pixel_in     <= pix;
      req_ray_distance <= ray_dist;
      taken = 0;
      // busy is stable between edges; hold the request until it is low
      while (!taken) begin
         taken = !busy;
         @(posedge clock);
         if (!taken)
            @(negedge clock);
      end
      requests_sent++;
   endtask

   // Drop start and wait until every pending request has come back.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      wait (pending == 0);
      repeat (dps_pkg::LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_view(input logic [dps_pkg::VIEW_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      view_now = value;
      settings_used++;
   endtask

   function automatic logic [dps_pkg::REQ_DIST_BITS-1:0] random_distance();
      int lo;
      int hi;
      lo = (view_now > 64) ? int'(view_now) - 64 : 0;
      hi = (view_now < 65535 - 64) ? int'(view_now) + 64 : 65535;
      case ($urandom_range(0, 3))
         0: return dps_pkg::REQ_DIST_BITS'($urandom_range(0, 15));
         1: return dps_pkg::REQ_DIST_BITS'($urandom_range(hi, lo));
         2: return dps_pkg::REQ_DIST_BITS'($urandom_range(0, 65535));
         default: return dps_pkg::REQ_DIST_BITS'($urandom
                                                  & ((32'd1 << $urandom_range(1, 16)) - 1));
      endcase
   endfunction

   function automatic logic [dps_pkg::PIX_BITS-1:0] random_pixel();
      logic [dps_pkg::PIX_BITS-1:0] pix;
      pix = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         // pin some channels to black or full scale
         for (int k = 0; k < dps_pkg::NUM_CHANS; k++) begin
            case ($urandom_range(0, 2))
               0: pix[k*dps_pkg::CHAN_BITS +: dps_pkg::CHAN_BITS] = '0;
               1: pix[k*dps_pkg::CHAN_BITS +: dps_pkg::CHAN_BITS] = '1;
               default: ;
            endcase
         end
      end
      return pix;
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++)
         send_request(random_pixel(), random_distance());
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_pixel_in     = '0;
      req_ray_distance = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      burst_left       = 0;
      requests_sent    = 0;
      settings_used    = 0;
      view_now         = dps_pkg::VIEW_RESET;
      view_plan = '{16'd2, 16'd65535, 16'd0, 16'd1, 16'd3, 16'd1000,
                    dps_pkg::VIEW_BITS'($urandom_range(2, 65535)),
                    dps_pkg::VIEW_BITS'($urandom_range(2, 300)),
                    dps_pkg::VIEW_BITS'($urandom_range(2, 65535)), dps_pkg::VIEW_RESET};
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed corners under the reset view distance
      send_request(32'hFFFF_FFFF, 16'd0);
      send_request(32'hFFFF_FFFF, 16'd1);
      send_request(32'hFFFF_FFFF, 16'd2);
      send_request(32'hFFFF_FFFF, 16'd255);
      send_request(32'hFFFF_FFFF, 16'd256);
      send_request(32'hFFFF_FFFF, 16'd257);
      send_request(32'hFFFF_FFFF, 16'hFFFF);
      send_request(32'hFFFF_FFFF, 16'h8000);
      send_request(32'h0000_0000, 16'd0);
      send_request(32'h0000_0000, 16'hFFFF);
      send_request(32'h8040_2010, 16'd256);
      send_request(32'h01FF_7F00, 16'd86);
      send_request(32'hFEDC_BA98, 16'd8000);
      send_request(32'h1234_5678, 16'd0);
      send_request(32'hFF00_FF00, 16'd512);
      run_random(110);

      foreach (view_plan[p]) begin
         settle();
         write_view(view_plan[p]);
         send_request(32'hFFFF_FFFF, 16'd0);
         send_request(32'hFFFF_FFFF, 16'd1);
         send_request(32'hFFFF_FFFF, view_now);
         send_request(32'hFFFF_FFFF, 16'hFFFF);
         run_random(100);
      end
      settle();

      $display("Covered %0d shading requests over %0d view distance writes,",
               requests_sent, settings_used);
      $display("including views 0, 1, 2 and 65535; %0d shaded pixels compared.", compared);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
